/* rtl/ptp_pkg.sv */
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types, constants and single-precision helpers for the point
// transform pipeline.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int SIG_W    = 48;
  localparam int DIV_BITS = 26;
  localparam int LAT_FP   = 3;
  localparam int LAT_DIV  = DIV_BITS + 3;

  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;

  localparam logic [2:0] REG_PERSP = 3'd6;

  typedef enum logic [1:0] {
    OP_AFFINE,
    OP_PROJECT,
    OP_HPROJECT,
    OP_UNPROJECT
  } op_t;

  // unpacked operand: effective exponent and mantissa with hidden bit
  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [7:0]  ex;
    logic [23:0] man;
  } fpu_t;

  // unrounded result: value = sig / 2^47 * 2^(ex - 127)
  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] ex;
    logic [SIG_W-1:0]   sig;
  } unr_t;

  function automatic fpu_t fp_unpack(input logic [31:0] f);
    fpu_t u;
    u.sign = f[31];
    u.nan  = (f[30:23] == 8'hFF) && (f[22:0] != '0);
    u.inf  = (f[30:23] == 8'hFF) && (f[22:0] == '0);
    u.zero = (f[30:0] == '0);
    u.ex   = (f[30:23] == '0) ? 8'd1 : f[30:23];
    u.man  = {f[30:23] != '0, f[22:0]};
    return u;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc48(input logic [SIG_W-1:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'(SIG_W);
    found = 1'b0;
    for (int i = SIG_W - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(SIG_W - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic unr_t fp_norm(input unr_t u);
    unr_t       r;
    logic [5:0] lz;
    r = u;
    lz = lzc48(u.sig);
    if (!u.nan && !u.inf && !u.zero) begin
      r.sig = u.sig << lz;
      r.ex  = $signed(u.ex) - $signed({5'b0, lz});
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_round(input unr_t u);
    logic [SIG_W-1:0] s;
    logic [SIG_W-1:0] mask;
    logic [10:0]      sh;
    logic [7:0]       eo;
    logic [23:0]      m;
    logic [30:0]      mag;
    logic             lost;
    logic             g;
    logic             st;
    logic             inc;
    logic [31:0]      res;
    s = u.sig;
    mask = '0;
    sh = '0;
    lost = 1'b0;
    eo = u.ex[7:0];
    if ($signed(u.ex) <= 0) begin
      sh = 11'(1 - $signed(u.ex));
      eo = '0;
      if (sh >= 11'(SIG_W)) begin
        lost = |u.sig;
        s = '0;
      end else begin
        mask = (48'd1 << sh[5:0]) - 48'd1;
        lost = |(u.sig & mask);
        s = u.sig >> sh[5:0];
      end
    end
    m = s[47:24];
    g = s[23];
    st = (|s[22:0]) | lost;
    inc = g & (st | m[0]);
    mag = {eo, m[22:0]} + 31'(inc);
    if (u.nan) begin
      res = FP_QNAN;
    end else if (u.inf) begin
      res = {u.sign, 8'hFF, 23'b0};
    end else if (u.zero) begin
      res = {u.sign, 31'b0};
    end else if ($signed(u.ex) >= 255) begin
      res = {u.sign, 8'hFF, 23'b0};
    end else begin
      res = {u.sign, mag};
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_canon(input logic [31:0] f);
    return ((f[30:23] == 8'hFF) && (f[22:0] != '0)) ? FP_QNAN : f;
  endfunction

endpackage

/* rtl/ptp_fmul.sv */
// ----------------------------------------------------------------------------
// ptp_fmul
// Three-stage single-precision multiplier: product, normalize, round.
// ----------------------------------------------------------------------------
module ptp_fmul (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  ptp_pkg::fpu_t ua;
  ptp_pkg::fpu_t ub;
  ptp_pkg::unr_t s1_next;
  ptp_pkg::unr_t s1;
  ptp_pkg::unr_t s2;

  always_comb begin
    ua = ptp_pkg::fp_unpack(a);
    ub = ptp_pkg::fp_unpack(b);
    s1_next.sign = ua.sign ^ ub.sign;
    s1_next.nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
    s1_next.inf  = !s1_next.nan & (ua.inf | ub.inf);
    s1_next.zero = !s1_next.nan & !s1_next.inf & (ua.zero | ub.zero);
    s1_next.ex   = $signed({3'b0, ua.ex}) + $signed({3'b0, ub.ex}) - 11'sd126;
    s1_next.sig  = ua.man * ub.man;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1 <= s1_next;
      s2 <= ptp_pkg::fp_norm(s1);
      y  <= ptp_pkg::fp_round(s2);
    end
  end

endmodule

/* rtl/ptp_fadd.sv */
// ----------------------------------------------------------------------------
// ptp_fadd
// Three-stage single-precision adder: align and add, normalize, round.
// ----------------------------------------------------------------------------
module ptp_fadd (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  ptp_pkg::fpu_t    ua;
  ptp_pkg::fpu_t    ub;
  ptp_pkg::fpu_t    ubig;
  ptp_pkg::fpu_t    usml;
  logic             swap;
  logic [7:0]       d;
  logic [47:0]      big;
  logic [47:0]      sml;
  logic [47:0]      aln;
  logic [47:0]      sum;
  logic             stk;
  ptp_pkg::unr_t    s1_next;
  ptp_pkg::unr_t    s1;
  ptp_pkg::unr_t    s2;

  always_comb begin
    ua = ptp_pkg::fp_unpack(a);
    ub = ptp_pkg::fp_unpack(b);
    swap = b[30:0] > a[30:0];
    ubig = swap ? ub : ua;
    usml = swap ? ua : ub;
    d = ubig.ex - usml.ex;
    big = {1'b0, ubig.man, 23'b0};
    sml = {1'b0, usml.man, 23'b0};
    if (d >= 8'd48) begin
      aln = '0;
      stk = |usml.man;
    end else begin
      aln = sml >> d[5:0];
      stk = |(sml & ((48'd1 << d[5:0]) - 48'd1));
    end
    aln[0] = aln[0] | stk;
    sum = (ubig.sign == usml.sign) ? big + aln : big - aln;
    s1_next.nan  = ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sign != ub.sign));
    s1_next.inf  = !s1_next.nan & (ua.inf | ub.inf);
    s1_next.zero = !s1_next.nan & !s1_next.inf & (sum == '0);
    if (s1_next.inf) begin
      s1_next.sign = ua.inf ? ua.sign : ub.sign;
    end else if (s1_next.zero) begin
      s1_next.sign = ua.sign & ub.sign;
    end else begin
      s1_next.sign = ubig.sign;
    end
    s1_next.ex  = $signed({3'b0, ubig.ex}) + 11'sd1;
    s1_next.sig = sum;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1 <= s1_next;
      s2 <= ptp_pkg::fp_norm(s1);
      y  <= ptp_pkg::fp_round(s2);
    end
  end

endmodule

/* rtl/ptp_fdiv.sv */
// ----------------------------------------------------------------------------
// ptp_fdiv
// Pipelined single-precision divider: operand normalize, one restoring
// quotient bit per stage, then normalize and round.
// ----------------------------------------------------------------------------
module ptp_fdiv (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  localparam int NB = ptp_pkg::DIV_BITS;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] ex;
    logic [24:0]        rem;
    logic [23:0]        dvs;
    logic [NB-1:0]      q;
  } dstage_t;

  ptp_pkg::fpu_t ua;
  ptp_pkg::fpu_t ub;
  logic [4:0]    lza;
  logic [4:0]    lzb;
  dstage_t       st0_next;
  dstage_t       st [NB+1];
  dstage_t       step_next [NB];
  ptp_pkg::unr_t nr_next;
  ptp_pkg::unr_t nr;

  always_comb begin
    ua = ptp_pkg::fp_unpack(a);
    ub = ptp_pkg::fp_unpack(b);
    lza = ptp_pkg::lzc24(ua.man);
    lzb = ptp_pkg::lzc24(ub.man);
    st0_next.sign = ua.sign ^ ub.sign;
    st0_next.nan  = ua.nan | ub.nan | (ua.inf & ub.inf) | (ua.zero & ub.zero);
    st0_next.inf  = !st0_next.nan & (ua.inf | ub.zero);
    st0_next.zero = !st0_next.nan & !st0_next.inf & (ua.zero | ub.inf);
    st0_next.ex   = ($signed({3'b0, ua.ex}) - $signed({6'b0, lza}))
                  - ($signed({3'b0, ub.ex}) - $signed({6'b0, lzb})) + 11'sd127;
    st0_next.rem  = {1'b0, ua.man << lza};
    st0_next.dvs  = ub.man << lzb;
    st0_next.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st[0] <= st0_next;
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_step
    logic        ge;
    logic [24:0] rd;

    always_comb begin
      ge = st[i].rem >= {1'b0, st[i].dvs};
      rd = ge ? st[i].rem - {1'b0, st[i].dvs} : st[i].rem;
      step_next[i] = st[i];
      step_next[i].rem = {rd[23:0], 1'b0};
      step_next[i].q = {st[i].q[NB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st[i+1] <= step_next[i];
      end
    end
  end

  always_comb begin
    nr_next.sign = st[NB].sign;
    nr_next.nan  = st[NB].nan;
    nr_next.inf  = st[NB].inf;
    nr_next.zero = st[NB].zero;
    nr_next.ex   = st[NB].ex;
    nr_next.sig  = {st[NB].q, |st[NB].rem, {(ptp_pkg::SIG_W - 1 - NB){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nr <= ptp_pkg::fp_norm(nr_next);
      y  <= ptp_pkg::fp_round(nr);
    end
  end

endmodule

/* rtl/point_transform_project.sv */
// ----------------------------------------------------------------------------
// point_transform_project
// 3x4 matrix point transform with perspective and orthographic projection.
// ----------------------------------------------------------------------------
// Unless the output stalls, one word is accepted every cycle; each gives one
// result word. Stages: a three-stage depth operand adder, the divider
// (operand normalize, one quotient bit per stage over 26 stages, normalize
// and round), five three-stage floating-point layers (products, perspective
// scale, two sums and offset) and the output register. A stall on the output
// holds the whole pipeline; no word is lost. The user must write matrix and
// mode registers only while the pipeline is empty; nothing enforces it.
// ----------------------------------------------------------------------------
module point_transform_project (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // x_bits, y_bits, z_bits
  input  logic [1:0]   s_tuser,   // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // out_x, out_y, out_z, out_w
);

  localparam int LF    = ptp_pkg::LAT_FP;
  localparam int PRE   = LF + ptp_pkg::LAT_DIV;
  localparam int POST  = 4 * LF;
  localparam int TOTAL = PRE + LF + POST;

  typedef struct packed {
    ptp_pkg::op_t op;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  z;
  } side_t;

  typedef struct packed {
    ptp_pkg::op_t     op;
    logic [31:0]      z;
    logic [31:0]      q;
    logic [2:0][31:0] r;
    logic [2:0][31:0] p1;
    logic [2:0][31:0] p2;
  } item_t;

  logic [31:0]      m [3][4];
  logic             persp;
  logic             ce;
  logic [TOTAL-1:0] vld;
  ptp_pkg::op_t     out_op;
  side_t            la [PRE];
  item_t            lb [LF];
  item_t            lc [POST];
  item_t            e [5];
  side_t            sd;
  side_t            sm;
  logic [31:0]      pre_b;
  logic [31:0]      pre_y;
  logic [31:0]      dv_a;
  logic [31:0]      dv_b;
  logic [31:0]      dv_y;
  logic [31:0]      cx [3];
  logic [31:0]      m1_a0 [3];
  logic [31:0]      m1_b0 [3];
  logic [31:0]      m1_a1 [3];
  logic [31:0]      m1_b1 [3];
  logic [31:0]      m1_y0 [3];
  logic [31:0]      m1_y1 [3];
  logic [31:0]      m1_y2 [3];
  logic [31:0]      m2_y [3];
  logic [31:0]      a1_y [3];
  logic [31:0]      a2_y [3];
  logic [31:0]      a3_b [3];
  logic [31:0]      a3_y [3];
  logic [31:0]      wv;
  logic             sel_m2;
  logic             sel_a1;
  logic             sel_a2;
  logic             sel_a3;

  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      persp <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          m[r][c] <= '0;
        end
      end
    end else if (cfg_we) begin
      if (cfg_index == ptp_pkg::REG_PERSP) begin
        persp <= cfg_data[0];
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          if (cfg_index == 3'(2 * r + c / 2)) begin
            m[r][c] <= (c % 2 == 0) ? cfg_data[63:32] : cfg_data[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      vld <= {vld[TOTAL-2:0], s_tvalid};
      m_tvalid <= vld[TOTAL-1];
    end
  end

  // depth operand for unproject: z + m22, or z - m23
  assign pre_b = persp ? m[2][2] : {~m[2][3][31], m[2][3][30:0]};

  ptp_fadd u_pre (.clk, .ce, .a(s_tdata[95:64]), .b(pre_b), .y(pre_y));

  assign sd = la[LF-1];

  always_comb begin
    dv_a = ptp_pkg::FP_NEG_ONE;
    dv_b = sd.z;
    if (sd.op == ptp_pkg::OP_UNPROJECT) begin
      dv_a = persp ? {~m[2][3][31], m[2][3][30:0]} : pre_y;
      dv_b = persp ? pre_y : m[2][2];
    end
  end

  ptp_fdiv u_div (.clk, .ce, .a(dv_a), .b(dv_b), .y(dv_y));

  always_ff @(posedge clk) begin
    if (ce) begin
      la[0] <= '{op: ptp_pkg::op_t'(s_tuser), x: s_tdata[31:0], y: s_tdata[63:32],
                 z: s_tdata[95:64]};
      for (int i = 1; i < PRE; i++) begin
        la[i] <= la[i-1];
      end
      lb[0].op <= sm.op;
      lb[0].z  <= sm.z;
      lb[0].q  <= dv_y;
      lb[0].r  <= '0;
      lb[0].p1 <= '0;
      lb[0].p2 <= '0;
      for (int i = 1; i < LF; i++) begin
        lb[i] <= lb[i-1];
      end
      for (int j = 0; j < 4; j++) begin
        lc[j*LF] <= e[j];
        for (int i = 1; i < LF; i++) begin
          lc[j*LF+i] <= lc[j*LF+i-1];
        end
      end
    end
  end

  assign sm = la[PRE-1];

  always_comb begin
    cx[0] = sm.x;
    cx[1] = sm.y;
    cx[2] = sm.z;
    for (int k = 0; k < 3; k++) begin
      m1_a0[k] = m[k][k];
      m1_b0[k] = cx[k];
      if (sm.op == ptp_pkg::OP_AFFINE) begin
        m1_a0[k] = m[k][0];
        m1_b0[k] = sm.x;
      end else if (k == 2 && persp && sm.op == ptp_pkg::OP_PROJECT) begin
        m1_a0[k] = m[2][3];
        m1_b0[k] = ptp_pkg::FP_ONE;
      end
      if (sm.op == ptp_pkg::OP_AFFINE) begin
        m1_a1[k] = m[k][1];
        m1_b1[k] = sm.y;
      end else if (k < 2) begin
        m1_a1[k] = m[k][2];
        m1_b1[k] = sm.z;
      end else begin
        m1_a1[k] = m[2][3];
        m1_b1[k] = ptp_pkg::FP_ONE;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    ptp_fmul u_m1_0 (.clk, .ce, .a(m1_a0[k]), .b(m1_b0[k]), .y(m1_y0[k]));
    ptp_fmul u_m1_1 (.clk, .ce, .a(m1_a1[k]), .b(m1_b1[k]), .y(m1_y1[k]));
    ptp_fmul u_m1_2 (.clk, .ce, .a(m[k][2]), .b(sm.z), .y(m1_y2[k]));
    ptp_fmul u_m2 (.clk, .ce, .a(e[0].r[k]), .b(e[0].q), .y(m2_y[k]));
    ptp_fadd u_a1 (.clk, .ce, .a(e[1].r[k]), .b(e[1].p1[k]), .y(a1_y[k]));
    ptp_fadd u_a2 (.clk, .ce, .a(e[2].r[k]), .b(e[2].p2[k]), .y(a2_y[k]));
    ptp_fadd u_a3 (.clk, .ce, .a(e[3].r[k]), .b(a3_b[k]), .y(a3_y[k]));
  end

  always_comb begin
    e[0] = lb[LF-1];
    for (int k = 0; k < 3; k++) begin
      e[0].r[k]  = m1_y0[k];
      e[0].p1[k] = m1_y1[k];
      e[0].p2[k] = m1_y2[k];
    end
    e[1] = lc[LF-1];
    e[2] = lc[2*LF-1];
    e[3] = lc[3*LF-1];
    e[4] = lc[4*LF-1];
    sel_m2 = persp && e[1].op == ptp_pkg::OP_PROJECT;
    sel_a1 = e[2].op == ptp_pkg::OP_AFFINE || (persp && e[2].op == ptp_pkg::OP_HPROJECT);
    sel_a2 = e[3].op == ptp_pkg::OP_AFFINE;
    sel_a3 = e[4].op != ptp_pkg::OP_UNPROJECT
          && !(persp && e[4].op == ptp_pkg::OP_HPROJECT);
    for (int k = 0; k < 3; k++) begin
      a3_b[k] = (e[3].op == ptp_pkg::OP_AFFINE || !persp) ? m[k][3]
              : {~m[k][2][31], m[k][2][30:0]};
      if (sel_m2) begin
        e[1].r[k] = m2_y[k];
      end
      if (sel_a1) begin
        e[2].r[k] = a1_y[k];
      end
      if (sel_a2) begin
        e[3].r[k] = a2_y[k];
      end
      if (sel_a3) begin
        e[4].r[k] = a3_y[k];
      end
    end
    wv = (persp && e[4].op == ptp_pkg::OP_HPROJECT) ? {~e[4].z[31], e[4].z[30:0]}
       : ptp_pkg::FP_ONE;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_op <= e[4].op;
      if (e[4].op == ptp_pkg::OP_UNPROJECT) begin
        m_tdata <= {96'b0, ptp_pkg::fp_canon(e[4].q)};
      end else begin
        m_tdata <= {ptp_pkg::fp_canon(wv), ptp_pkg::fp_canon(e[4].r[2]),
                    ptp_pkg::fp_canon(e[4].r[1]), ptp_pkg::fp_canon(e[4].r[0])};
      end
    end
  end

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(vld))
    else $error("pipeline advanced during a stall");

  a_unproj_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_op == ptp_pkg::OP_UNPROJECT |-> m_tdata[127:32] == '0)
    else $error("unproject word carries nonzero y, z or w");

  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30:23] == 8'hFF && m_tdata[22:0] != '0
    |-> m_tdata[31:0] == ptp_pkg::FP_QNAN)
    else $error("non-canonical NaN on out_x");
`endif

endmodule
